// ===== rtl/cpm_pkg.sv =====
// Shared types, codes and saturating helpers for the covariance partial merge.
// No dependencies; every other file except cpm_fifo references this package by scoped names.
`timescale 1ns / 1ps

package cpm_pkg;

  localparam logic [1:0] KIND_COUNT = 2'd0;
  localparam logic [1:0] KIND_MEAN  = 2'd1;
  localparam logic [1:0] KIND_COMOM = 2'd2;

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
  localparam int RECIP_SHIFT   = 62;
  localparam int QUOT_BITS     = 63;

  typedef struct packed {
    logic [1:0]         kind;
    logic               starts_first_partial;
    logic [31:0]        sample_count;
    logic [3:0]         var_a;
    logic [3:0]         var_b;
    logic [7:0]         slot;
    logic signed [63:0] value;
  } item_t;

  typedef struct packed {
    logic signed [63:0] merged_value;
    logic [31:0]        total_count;
    logic               saturated;
  } result_t;

  typedef enum logic [1:0] {OP_START, OP_COUNT, OP_MEAN, OP_COMOM} op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] cnt;
    logic [3:0]  va;
    logic [3:0]  vb;
    logic [7:0]  slot;
    logic [63:0] value;
  } cmd_t;

  typedef enum logic [1:0] {SH_NONE, SH_FRAC, SH_RECIP} sh_e;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] mb;
    logic        bneg;
    sh_e         sh;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
    logic [63:0] raw;
    logic        sat;
  } mul_rsp_t;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_RND, M_OUT} mul_state_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_COUNT, ST_DIV, ST_COPY, ST_SUB, ST_MDN, ST_MINC,
    ST_MADD, ST_PROD, ST_MP, ST_MT, ST_CADD1, ST_CADD2, ST_DONE
  } back_state_e;

  function automatic logic [63:0] mag(logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  // {saturated, sum}
  function automatic logic [64:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return {1'b1, (a[63] ? SMIN : SMAX)};
    return {1'b0, s};
  endfunction

  function automatic logic [64:0] sub_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if (a[63] != b[63] && d[63] != a[63]) return {1'b1, (a[63] ? SMIN : SMAX)};
    return {1'b0, d};
  endfunction

endpackage

// ===== rtl/cpm_fifo.sv =====
// Small word queue with combinational head read.
// Standalone; used for the command queue and the result queue.
`timescale 1ns / 1ps

module cpm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/cpm_front.sv =====
// Front end: takes input words, drops unknown kinds, decodes the operation
// and folds indexes into range. Depends on cpm_pkg.
`timescale 1ns / 1ps

module cpm_front #(
  parameter int MAX_VARIABLES = 16,
  parameter int MAX_COMOMENTS = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cpm_pkg::item_t item_i,
  input  logic          push_i,
  output logic          full_o,
  output cpm_pkg::cmd_t cmd_o,
  output logic          cmd_push_o,
  input  logic          cmd_full_i
);

  logic [3:0] va_tbl [16];
  logic [7:0] slot_tbl [256];

  for (genvar g = 0; g < 16; g++) begin : g_va
    localparam int unsigned R = g % MAX_VARIABLES;
    assign va_tbl[g] = 4'(R);
  end

  for (genvar g = 0; g < 256; g++) begin : g_slot
    localparam int unsigned R = g % MAX_COMOMENTS;
    assign slot_tbl[g] = 8'(R);
  end

  cpm_pkg::cmd_t hold_q, dec;
  logic          vld_q, vld_d, accept;

  assign full_o     = vld_q && cmd_full_i;
  assign accept     = push_i && !full_o;
  assign cmd_push_o = vld_q;
  assign cmd_o      = hold_q;

  always_comb begin
    dec.cnt   = item_i.sample_count;
    dec.va    = va_tbl[item_i.var_a];
    dec.vb    = va_tbl[item_i.var_b];
    dec.slot  = slot_tbl[item_i.slot];
    dec.value = item_i.value;
    case (item_i.kind)
      cpm_pkg::KIND_COUNT: begin
        dec.op = item_i.starts_first_partial ? cpm_pkg::OP_START : cpm_pkg::OP_COUNT;
      end
      cpm_pkg::KIND_MEAN:  dec.op = cpm_pkg::OP_MEAN;
      default:             dec.op = cpm_pkg::OP_COMOM;
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = (item_i.kind == cpm_pkg::KIND_COUNT) || (item_i.kind == cpm_pkg::KIND_MEAN)
           || (item_i.kind == cpm_pkg::KIND_COMOM);
    end else if (vld_q && !cmd_full_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= dec;
    end
  end

endmodule

// ===== rtl/cpm_mul.sv =====
// Sequential 64x64 magnitude multiplier on one 32x32 unit with rounding
// shift and signed saturation. Depends on cpm_pkg.
`timescale 1ns / 1ps

module cpm_mul #(
  parameter int FRAC_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpm_pkg::mul_req_t req_i,
  output cpm_pkg::mul_rsp_t rsp_o
);

  cpm_pkg::mul_state_e state_q, state_d;
  logic [63:0]  ma_q, mb_q, pp_q, lo, limit;
  logic         neg_q;
  cpm_pkg::sh_e sh_q;
  logic [2:0]   step_q;
  logic [1:0]   psh_q;
  logic [127:0] acc_q, shr_q, pp_sh, rnd, rconst;
  logic [31:0]  a_part, b_part;
  logic         sat;

  assign a_part = step_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign b_part = step_q[0] ? mb_q[63:32] : mb_q[31:0];

  always_comb begin
    case (psh_q)
      2'd0:    pp_sh = {64'd0, pp_q};
      2'd1:    pp_sh = {32'd0, pp_q, 32'd0};
      default: pp_sh = {pp_q, 64'd0};
    endcase
  end

  always_comb begin
    case (sh_q)
      cpm_pkg::SH_FRAC:  rconst = 128'd1 << (FRAC_BITS - 1);
      cpm_pkg::SH_RECIP: rconst = 128'd1 << (cpm_pkg::RECIP_SHIFT - 1);
      default:           rconst = '0;
    endcase
    rnd = acc_q + rconst;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cpm_pkg::M_IDLE: if (req_i.start) state_d = cpm_pkg::M_MUL;
      cpm_pkg::M_MUL:  if (step_q == 3'd4) state_d = cpm_pkg::M_RND;
      cpm_pkg::M_RND:  state_d = cpm_pkg::M_OUT;
      cpm_pkg::M_OUT:  state_d = cpm_pkg::M_IDLE;
      default:         state_d = cpm_pkg::M_IDLE;
    endcase
  end

  always_comb begin
    lo         = shr_q[63:0];
    limit      = neg_q ? cpm_pkg::SMIN : cpm_pkg::SMAX;
    sat        = (|shr_q[127:64]) || (lo > limit);
    rsp_o.done = (state_q == cpm_pkg::M_OUT);
    rsp_o.sat  = sat;
    rsp_o.res  = sat ? limit : (neg_q ? (64'd0 - lo) : lo);
    rsp_o.raw  = acc_q[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpm_pkg::M_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= (state_q == cpm_pkg::M_MUL) ? step_q + 3'd1 : 3'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      cpm_pkg::M_IDLE: begin
        if (req_i.start) begin
          ma_q  <= cpm_pkg::mag(req_i.a);
          mb_q  <= req_i.mb;
          neg_q <= req_i.a[63] ^ req_i.bneg;
          sh_q  <= req_i.sh;
          acc_q <= '0;
        end
      end
      cpm_pkg::M_MUL: begin
        if (step_q != 3'd4) begin
          pp_q  <= 64'(a_part) * 64'(b_part);
          psh_q <= 2'(step_q[1]) + 2'(step_q[0]);
        end
        if (step_q != 3'd0) begin
          acc_q <= acc_q + pp_sh;
        end
      end
      cpm_pkg::M_RND: begin
        case (sh_q)
          cpm_pkg::SH_FRAC:  shr_q <= rnd >> FRAC_BITS;
          cpm_pkg::SH_RECIP: shr_q <= rnd >> cpm_pkg::RECIP_SHIFT;
          default:           shr_q <= acc_q;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/cpm_back.sv =====
// Back end sequencer: counts, reciprocal divide, mean and co-moment updates
// with state memories. Depends on cpm_pkg; drives cpm_mul.
`timescale 1ns / 1ps

module cpm_back #(
  parameter int MAX_VARIABLES = 16,
  parameter int MAX_COMOMENTS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_empty_i,
  input  cpm_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output cpm_pkg::result_t  res_o,
  output cpm_pkg::mul_req_t mul_req_o,
  input  cpm_pkg::mul_rsp_t mul_rsp_i
);

  localparam int VW = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
  localparam int SW = (MAX_COMOMENTS > 1) ? $clog2(MAX_COMOMENTS) : 1;

  logic [63:0] mean_mem [MAX_VARIABLES];
  logic [63:0] md_mem   [MAX_VARIABLES];
  logic [63:0] dot_mem  [MAX_VARIABLES];
  logic [63:0] com_mem  [MAX_COMOMENTS];

  cpm_pkg::back_state_e state_q, state_d;
  cpm_pkg::cmd_t        cmd_q;
  logic        copy_q, mwait_q, sat_q, is_mul, is_mean, mean_we, com_we;
  logic [31:0] mcount_q, prev_q, part_q, cnt_new, rem_q;
  logic [63:0] recip_q, mean_rd_q, md_rd_q, dot_rd_q, com_rd_q;
  logic [63:0] d_q, dn_q, inc_q, prod_q, p_q, term_q, c_q, res_q;
  logic [63:0] mean_wd, md_wd, dot_wd, com_wd;
  logic [62:0] quot_q;
  logic [5:0]  div_cnt_q;
  logic [32:0] sum, r;
  logic        ovf, ge;
  logic [64:0] sub_r, madd_r, cadd1_r, cadd2_r;
  logic [VW-1:0] va, vb;
  logic [SW-1:0] slot;

  assign va      = VW'(cmd_q.va);
  assign vb      = VW'(cmd_q.vb);
  assign slot    = SW'(cmd_q.slot);
  assign is_mean = (cmd_q.op == cpm_pkg::OP_MEAN);

  assign sum     = {1'b0, mcount_q} + {1'b0, cmd_q.cnt};
  assign ovf     = (cmd_q.op == cpm_pkg::OP_COUNT) && sum[32];
  always_comb begin
    if (cmd_q.op == cpm_pkg::OP_START) cnt_new = cmd_q.cnt;
    else if (sum[32])                  cnt_new = '1;
    else                               cnt_new = sum[31:0];
  end

  assign r  = {rem_q, (div_cnt_q == 6'(cpm_pkg::QUOT_BITS - 1))};
  assign ge = (r >= {1'b0, mcount_q});

  assign sub_r   = cpm_pkg::sub_sat(cmd_q.value, mean_rd_q);
  assign madd_r  = cpm_pkg::add_sat(mean_rd_q, inc_q);
  assign cadd1_r = cpm_pkg::add_sat(com_rd_q, cmd_q.value);
  assign cadd2_r = cpm_pkg::add_sat(c_q, term_q);

  assign is_mul = (state_q == cpm_pkg::ST_MDN) || (state_q == cpm_pkg::ST_MINC)
               || (state_q == cpm_pkg::ST_PROD) || (state_q == cpm_pkg::ST_MP)
               || (state_q == cpm_pkg::ST_MT);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpm_pkg::ST_IDLE:  if (!cmd_empty_i) state_d = cpm_pkg::ST_READ;
      cpm_pkg::ST_READ: begin
        if (cmd_q.op == cpm_pkg::OP_START || cmd_q.op == cpm_pkg::OP_COUNT) begin
          state_d = cpm_pkg::ST_COUNT;
        end else if (copy_q) begin
          state_d = cpm_pkg::ST_COPY;
        end else begin
          state_d = is_mean ? cpm_pkg::ST_SUB : cpm_pkg::ST_PROD;
        end
      end
      cpm_pkg::ST_COUNT: state_d = (cnt_new == '0) ? cpm_pkg::ST_DONE : cpm_pkg::ST_DIV;
      cpm_pkg::ST_DIV:   if (div_cnt_q == '0) state_d = cpm_pkg::ST_DONE;
      cpm_pkg::ST_COPY:  state_d = cpm_pkg::ST_DONE;
      cpm_pkg::ST_SUB:   state_d = cpm_pkg::ST_MDN;
      cpm_pkg::ST_MDN:   if (mul_rsp_i.done) state_d = cpm_pkg::ST_MINC;
      cpm_pkg::ST_MINC:  if (mul_rsp_i.done) state_d = cpm_pkg::ST_MADD;
      cpm_pkg::ST_MADD:  state_d = cpm_pkg::ST_DONE;
      cpm_pkg::ST_PROD:  if (mul_rsp_i.done) state_d = cpm_pkg::ST_MP;
      cpm_pkg::ST_MP:    if (mul_rsp_i.done) state_d = cpm_pkg::ST_MT;
      cpm_pkg::ST_MT:    if (mul_rsp_i.done) state_d = cpm_pkg::ST_CADD1;
      cpm_pkg::ST_CADD1: state_d = cpm_pkg::ST_CADD2;
      cpm_pkg::ST_CADD2: state_d = cpm_pkg::ST_DONE;
      cpm_pkg::ST_DONE:  if (!res_full_i) state_d = cpm_pkg::ST_IDLE;
      default:           state_d = cpm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o          = (state_q == cpm_pkg::ST_IDLE) && !cmd_empty_i;
    res_push_o         = (state_q == cpm_pkg::ST_DONE) && !res_full_i;
    res_o.merged_value = res_q;
    res_o.total_count  = mcount_q;
    res_o.saturated    = sat_q;
    mul_req_o.start    = is_mul && !mwait_q;
    mul_req_o.a        = d_q;
    mul_req_o.mb       = recip_q;
    mul_req_o.bneg     = 1'b0;
    mul_req_o.sh       = cpm_pkg::SH_NONE;
    mean_we            = 1'b0;
    com_we             = 1'b0;
    mean_wd            = cmd_q.value;
    md_wd              = '0;
    dot_wd             = '0;
    com_wd             = cmd_q.value;
    case (state_q)
      cpm_pkg::ST_MDN:  mul_req_o.sh = cpm_pkg::SH_RECIP;
      cpm_pkg::ST_MINC: begin
        mul_req_o.a  = dn_q;
        mul_req_o.mb = {32'd0, part_q};
      end
      cpm_pkg::ST_PROD: begin
        mul_req_o.a  = {32'd0, prev_q};
        mul_req_o.mb = {32'd0, part_q};
      end
      cpm_pkg::ST_MP: begin
        mul_req_o.a    = md_rd_q;
        mul_req_o.mb   = cpm_pkg::mag(dot_rd_q);
        mul_req_o.bneg = dot_rd_q[63];
        mul_req_o.sh   = cpm_pkg::SH_FRAC;
      end
      cpm_pkg::ST_MT: begin
        mul_req_o.a  = p_q;
        mul_req_o.mb = prod_q;
      end
      cpm_pkg::ST_COPY: begin
        mean_we = is_mean;
        com_we  = !is_mean;
      end
      cpm_pkg::ST_MADD: begin
        mean_we = 1'b1;
        mean_wd = madd_r[63:0];
        md_wd   = d_q;
        dot_wd  = dn_q;
      end
      cpm_pkg::ST_CADD2: begin
        com_we = 1'b1;
        com_wd = cadd2_r[63:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cpm_pkg::ST_IDLE;
      mwait_q   <= 1'b0;
      copy_q    <= 1'b0;
      mcount_q  <= '0;
      prev_q    <= '0;
      part_q    <= '0;
      recip_q   <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (mul_rsp_i.done)       mwait_q <= 1'b0;
      else if (mul_req_o.start) mwait_q <= 1'b1;
      case (state_q)
        cpm_pkg::ST_COUNT: begin
          copy_q    <= (cmd_q.op == cpm_pkg::OP_START);
          prev_q    <= (cmd_q.op == cpm_pkg::OP_START) ? '0 : mcount_q;
          part_q    <= cmd_q.cnt;
          mcount_q  <= cnt_new;
          div_cnt_q <= 6'(cpm_pkg::QUOT_BITS - 1);
          if (cnt_new == '0) recip_q <= '0;
        end
        cpm_pkg::ST_DIV: begin
          div_cnt_q <= div_cnt_q - 6'd1;
          if (div_cnt_q == '0) recip_q <= {1'b0, quot_q[61:0], ge};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      cpm_pkg::ST_IDLE: if (!cmd_empty_i) cmd_q <= cmd_i;
      cpm_pkg::ST_READ: begin
        sat_q     <= 1'b0;
        mean_rd_q <= mean_mem[va];
        md_rd_q   <= md_mem[va];
        dot_rd_q  <= dot_mem[vb];
        com_rd_q  <= com_mem[slot];
      end
      cpm_pkg::ST_COUNT: begin
        sat_q  <= ovf;
        res_q  <= '0;
        rem_q  <= '0;
        quot_q <= '0;
      end
      cpm_pkg::ST_DIV: begin
        rem_q  <= ge ? 32'(r - {1'b0, mcount_q}) : r[31:0];
        quot_q <= {quot_q[61:0], ge};
      end
      cpm_pkg::ST_COPY: res_q <= cmd_q.value;
      cpm_pkg::ST_SUB: begin
        d_q   <= sub_r[63:0];
        sat_q <= sat_q | sub_r[64];
      end
      cpm_pkg::ST_MDN: if (mul_rsp_i.done) begin
        dn_q  <= mul_rsp_i.res;
        sat_q <= sat_q | mul_rsp_i.sat;
      end
      cpm_pkg::ST_MINC: if (mul_rsp_i.done) begin
        inc_q <= mul_rsp_i.res;
        sat_q <= sat_q | mul_rsp_i.sat;
      end
      cpm_pkg::ST_MADD: begin
        res_q <= madd_r[63:0];
        sat_q <= sat_q | madd_r[64];
      end
      cpm_pkg::ST_PROD: if (mul_rsp_i.done) prod_q <= mul_rsp_i.raw;
      cpm_pkg::ST_MP: if (mul_rsp_i.done) begin
        p_q   <= mul_rsp_i.res;
        sat_q <= sat_q | mul_rsp_i.sat;
      end
      cpm_pkg::ST_MT: if (mul_rsp_i.done) begin
        term_q <= mul_rsp_i.res;
        sat_q  <= sat_q | mul_rsp_i.sat;
      end
      cpm_pkg::ST_CADD1: begin
        c_q   <= cadd1_r[63:0];
        sat_q <= sat_q | cadd1_r[64];
      end
      cpm_pkg::ST_CADD2: begin
        res_q <= cadd2_r[63:0];
        sat_q <= sat_q | cadd2_r[64];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mean_we) begin
      mean_mem[va] <= mean_wd;
      md_mem[va]   <= md_wd;
      dot_mem[va]  <= dot_wd;
    end
    if (com_we) begin
      com_mem[slot] <= com_wd;
    end
  end

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cpm_pkg::ST_DIV) |-> (mcount_q != '0))
    else $error("divide with zero count");
  a_mul_requested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp_i.done |-> mwait_q)
    else $error("multiplier result without request");
  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cpm_pkg::ST_COUNT && cmd_q.op == cpm_pkg::OP_START)
      |=> (copy_q && prev_q == '0))
    else $error("first partial did not clear");
  a_copy_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(copy_q) |-> ($past(state_q) == cpm_pkg::ST_COUNT))
    else $error("copy flag set outside count word");
`endif

endmodule

// ===== rtl/covariance_partial_merge.sv =====
// Top level: front decoder, command queue, back sequencer with multiplier,
// result queue. Depends on cpm_pkg, cpm_fifo, cpm_front, cpm_mul, cpm_back.
//
//   port         dir  handshake      word
//   item_i       in   push / full    cpm_pkg::item_t
//   result_o     out  pop / empty    cpm_pkg::result_t
//
// One word at a time in the back end, from command pop to result push.
// Count words run the bit-serial 63-step reciprocal divide (skipped if the
// total is zero). Mean and co-moment merges use the shared 32x32 multiplier
// for each 64x64 product; copies need no multiply.
// Reset clears counts and control, not the memories. A full result queue holds
// the back end; a one-word front register and two-entry queues decouple stalls.
`timescale 1ns / 1ps

module covariance_partial_merge #(
  parameter int MAX_VARIABLES = 16,
  parameter int MAX_COMOMENTS = 256,
  parameter int FRAC_BITS     = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cpm_pkg::item_t   item_i,
  input  logic             push,
  output logic             full,
  output cpm_pkg::result_t result_o,
  output logic             empty,
  input  logic             pop
);

  cpm_pkg::cmd_t     f_cmd, b_cmd;
  cpm_pkg::result_t  b_res;
  cpm_pkg::mul_req_t mreq;
  cpm_pkg::mul_rsp_t mrsp;
  logic f_push, cq_full, cq_empty, b_pop, r_push, rq_full;

  cpm_front #(.MAX_VARIABLES(MAX_VARIABLES), .MAX_COMOMENTS(MAX_COMOMENTS)) u_front (
    .clk_i, .rst_ni, .item_i, .push_i(push), .full_o(full),
    .cmd_o(f_cmd), .cmd_push_o(f_push), .cmd_full_i(cq_full)
  );

  cpm_fifo #(.WIDTH($bits(cpm_pkg::cmd_t)), .DEPTH(2)) u_cmdq (
    .clk_i, .rst_ni, .push_i(f_push), .wdata_i(f_cmd), .full_o(cq_full),
    .pop_i(b_pop), .rdata_o(b_cmd), .empty_o(cq_empty)
  );

  cpm_back #(.MAX_VARIABLES(MAX_VARIABLES), .MAX_COMOMENTS(MAX_COMOMENTS)) u_back (
    .clk_i, .rst_ni, .cmd_empty_i(cq_empty), .cmd_i(b_cmd), .cmd_pop_o(b_pop),
    .res_full_i(rq_full), .res_push_o(r_push), .res_o(b_res),
    .mul_req_o(mreq), .mul_rsp_i(mrsp)
  );

  cpm_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp)
  );

  cpm_fifo #(.WIDTH($bits(cpm_pkg::result_t)), .DEPTH(2)) u_resq (
    .clk_i, .rst_ni, .push_i(r_push), .wdata_i(b_res), .full_o(rq_full),
    .pop_i(pop), .rdata_o(result_o), .empty_o(empty)
  );

endmodule
